### rtl/plpr_pkg.sv
// shared types, constants and register codes for the power limit pwm ramp
package plpr_pkg;

  localparam int unsigned DutyW   = 6;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CurW    = 16;
  localparam int unsigned PwrW    = 20;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 3;

  // duty codes
  localparam logic [DutyW-1:0] DutyJump   = 6'd16;
  localparam logic [DutyW-1:0] DutyTop    = 6'd31;
  localparam logic [DutyW-1:0] DutyStatic = 6'd32;

  // fast ramp interval in ms
  localparam logic [CfgW-1:0] FastPeriodMs = 16'd2;

  // power limits in mW
  localparam logic [PwrW-1:0] LimFullMw = 20'd100000;
  localparam logic [PwrW-1:0] Lim3qMw   = 20'd75000;
  localparam logic [PwrW-1:0] LimHalfMw = 20'd50000;

  // reset values of the configuration registers
  localparam logic [1:0]      RstPowerMode    = 2'd0;
  localparam logic [CfgW-1:0] RstShortThrMa   = 16'd5800;
  localparam logic [CfgW-1:0] RstShortTimeMs  = 16'd100;
  localparam logic [CfgW-1:0] RstUpdPeriodMs  = 16'd20;
  localparam logic [CfgW-1:0] RstCurLimitMa   = 16'd5200;
  localparam logic            RstCurLimitEn   = 1'b1;

  typedef enum logic [1:0] {
    CmdTick    = 2'd0,
    CmdForce   = 2'd1,
    CmdRelease = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    Mode100W = 2'd0,
    Mode75W  = 2'd1,
    Mode50W  = 2'd2
  } power_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegPowerMode   = 3'd0,
    RegShortThr    = 3'd1,
    RegShortTime   = 3'd2,
    RegUpdPeriod   = 3'd3,
    RegCurLimit    = 3'd4,
    RegCurLimitEn  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]      power_mode;
    logic [CfgW-1:0] short_thr_ma;
    logic [CfgW-1:0] short_time_ms;
    logic [CfgW-1:0] upd_period_ms;
    logic [CfgW-1:0] cur_limit_ma;
    logic            cur_limit_en;
  } cfg_t;

endpackage

### rtl/plpr_cfg_regs.sv
// configuration register file of the power limit pwm ramp
module plpr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [plpr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [plpr_pkg::CfgW-1:0]     cfg_data_i,
  output plpr_pkg::cfg_t                cfg_o
);
  import plpr_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegPowerMode: begin
          // the unused mode code leaves the limit as it is
          if (cfg_data_i[1:0] != 2'd3) begin
            cfg_d.power_mode = cfg_data_i[1:0];
          end
        end
        RegShortThr:   cfg_d.short_thr_ma  = cfg_data_i;
        RegShortTime:  cfg_d.short_time_ms = cfg_data_i;
        RegUpdPeriod:  cfg_d.upd_period_ms = cfg_data_i;
        RegCurLimit:   cfg_d.cur_limit_ma  = cfg_data_i;
        RegCurLimitEn: cfg_d.cur_limit_en  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_mode    <= RstPowerMode;
      cfg_q.short_thr_ma  <= RstShortThrMa;
      cfg_q.short_time_ms <= RstShortTimeMs;
      cfg_q.upd_period_ms <= RstUpdPeriodMs;
      cfg_q.cur_limit_ma  <= RstCurLimitMa;
      cfg_q.cur_limit_en  <= RstCurLimitEn;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/power_limit_pwm_ramp.sv
// top level of the power limit pwm ramp: input stage, step logic, result register
//
// channel   | dir | handshake                    | payload
// ----------+-----+------------------------------+-----------------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tuser: cmd; tdata: now, current, power
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: duty, limiting, fault, changed
// cfg       | in  | cfg_we_i (no wait)           | cfg_idx_i, cfg_data_i
//
// one item per cycle sustained while m_axis takes results; an item's result is offered on m_axis
// once it has passed the input register, then the single-pass step logic into the result register
// the state registers and the result register load in the same cycle, so each item
// sees the state left by the one before it
// reset clears the state, the stage valids and loads the register defaults
// a stalled m_axis holds the result; the input register still takes one more item
module power_limit_pwm_ramp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [71:0]                   s_axis_tdata,  // now_ms, cur_ma, power_mw
  input  logic [1:0]                    s_axis_tuser,  // cmd
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // pwm_duty, current_limiting,
                                                       // short_fault, duty_changed
  input  logic                          cfg_we_i,
  input  logic [plpr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [plpr_pkg::CfgW-1:0]     cfg_data_i
);
  import plpr_pkg::*;

  cfg_t cfg;

  plpr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // input register
  logic             in_valid_q;
  logic [1:0]       in_cmd_q;
  logic [TimeW-1:0] in_now_q;
  logic [CurW-1:0]  in_cur_q;
  logic [PwrW-1:0]  in_pwr_q;

  // block state
  logic [DutyW-1:0] duty_q, duty_d;
  logic [TimeW-1:0] last_upd_q, last_upd_d;
  logic [PwrW-1:0]  prev_pwr_q, prev_pwr_d;
  logic [CurW-1:0]  prev_cur_q, prev_cur_d;
  logic [TimeW-1:0] short_start_q, short_start_d;
  logic             short_timing_q, short_timing_d;
  logic             forced_q, forced_d;
  logic             limiting_q, limiting_d;
  logic             fault_q, fault_d;

  // result register
  logic             out_valid_q;
  logic [DutyW-1:0] out_duty_q;
  logic             out_lim_q;
  logic             out_fault_q;
  logic             out_chg_q;

  logic step_en;
  logic in_take;

  assign step_en       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step_en;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // compares on the registered item
  logic [PwrW-1:0]  pwr_lim;
  logic             over_thr;
  logic             short_done;
  logic             up_pwr;
  logic             cur_hit;
  logic             ramp_up;
  logic [CfgW-1:0]  period;
  logic             period_done;
  logic [TimeW-1:0] short_age;
  logic [TimeW-1:0] upd_age;
  logic [DutyW-1:0] duty_ramp;

  always_comb begin
    unique case (power_mode_e'(cfg.power_mode))
      Mode50W: pwr_lim = LimHalfMw;
      Mode75W: pwr_lim = Lim3qMw;
      default: pwr_lim = LimFullMw;
    endcase
  end

  assign over_thr    = in_cur_q > cfg.short_thr_ma;
  assign short_age   = in_now_q - short_start_q;
  assign short_done  = short_age >= {{(TimeW-CfgW){1'b0}}, cfg.short_time_ms};
  assign up_pwr      = (in_pwr_q > pwr_lim) || (prev_pwr_q > pwr_lim);
  assign cur_hit     = cfg.cur_limit_en &&
                       ((in_cur_q >= cfg.cur_limit_ma) || (prev_cur_q >= cfg.cur_limit_ma));
  assign ramp_up     = up_pwr || cur_hit;
  assign period      = ramp_up ? FastPeriodMs : cfg.upd_period_ms;
  assign upd_age     = in_now_q - last_upd_q;
  assign period_done = upd_age >= {{(TimeW-CfgW){1'b0}}, period};

  // fast ramp jumps to mid scale then climbs; 31 and static high hold; else the duty steps down to zero
  always_comb begin
    if (ramp_up) begin
      if (duty_q < DutyJump) begin
        duty_ramp = DutyJump;
      end else if (duty_q < DutyTop) begin
        duty_ramp = duty_q + 6'd1;
      end else begin
        duty_ramp = duty_q;
      end
    end else if (duty_q != '0) begin
      duty_ramp = duty_q - 6'd1;
    end else begin
      duty_ramp = duty_q;
    end
  end

  always_comb begin
    duty_d         = duty_q;
    last_upd_d     = last_upd_q;
    prev_pwr_d     = prev_pwr_q;
    prev_cur_d     = prev_cur_q;
    short_start_d  = short_start_q;
    short_timing_d = short_timing_q;
    forced_d       = forced_q;
    limiting_d     = limiting_q;
    fault_d        = fault_q;
    if (step_en && !fault_q) begin
      unique case (cmd_e'(in_cmd_q))
        CmdTick: begin
          if (over_thr) begin
            if (!short_timing_q) begin
              short_start_d  = in_now_q;
              short_timing_d = 1'b1;
            end else if (short_done) begin
              fault_d = 1'b1;
            end
          end else begin
            short_timing_d = 1'b0;
          end
          // the latching tick does nothing more
          if (!(over_thr && short_timing_q && short_done)) begin
            if (forced_q) begin
              limiting_d = 1'b0;
            end else begin
              prev_pwr_d = in_pwr_q;
              limiting_d = cur_hit;
              if (cfg.cur_limit_en) begin
                prev_cur_d = in_cur_q;
              end
              if (period_done) begin
                last_upd_d = in_now_q;
                duty_d     = duty_ramp;
              end
            end
          end
        end
        CmdForce: begin
          forced_d   = 1'b1;
          limiting_d = 1'b0;
          duty_d     = DutyStatic;
        end
        CmdRelease: begin
          if (forced_q) begin
            duty_d     = DutyTop;
            last_upd_d = in_now_q;
            forced_d   = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      duty_q         <= '0;
      last_upd_q     <= '0;
      prev_pwr_q     <= '0;
      prev_cur_q     <= '0;
      short_start_q  <= '0;
      short_timing_q <= 1'b0;
      forced_q       <= 1'b0;
      limiting_q     <= 1'b0;
      fault_q        <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step_en) begin
        in_valid_q <= 1'b0;
      end
      if (step_en) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      duty_q         <= duty_d;
      last_upd_q     <= last_upd_d;
      prev_pwr_q     <= prev_pwr_d;
      prev_cur_q     <= prev_cur_d;
      short_start_q  <= short_start_d;
      short_timing_q <= short_timing_d;
      forced_q       <= forced_d;
      limiting_q     <= limiting_d;
      fault_q        <= fault_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q <= s_axis_tuser;
      in_now_q <= s_axis_tdata[31:0];
      in_cur_q <= s_axis_tdata[47:32];
      in_pwr_q <= s_axis_tdata[67:48];
    end
    if (step_en) begin
      out_duty_q  <= duty_d;
      out_lim_q   <= limiting_d;
      out_fault_q <= fault_d;
      out_chg_q   <= duty_d != duty_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_chg_q, out_fault_q, out_lim_q, out_duty_q};

  duty_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q <= DutyStatic)
    else $error("duty above static high");

  fault_sticky_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q |=> fault_q && $stable(duty_q))
    else $error("state moved after fault latched");

  forced_static_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    forced_q |-> (duty_q == DutyStatic) && !limiting_q)
    else $error("forced minimum without static high");

  step_result_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en |=> out_valid_q)
    else $error("stepped item produced no result");

  in_hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step_en) |=> in_valid_q && $stable(in_now_q) && $stable(in_cmd_q))
    else $error("stalled item lost in the input register");

endmodule
